[hw/rtl/olfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olfs_pkg: shared definitions for the open-loop FOC / SVPWM block
// Fixed-point constants, register indexes and the sequencer state codes.
// ----------------------------------------------------------------------------
package olfs_pkg;

	// Default electrical angle resolution in bits (turn fraction).
	localparam int ANGLE_BITS_DEF = 16;

	// Fixed-point constants.
	localparam logic [28:0] PI3_Q28           = 29'd281104952;
	localparam logic [28:0] SQRT3_Q28         = 29'd464943848;
	localparam logic [28:0] ONE_Q28           = 29'd268435456;
	localparam logic [25:0] INV_TWO_PI_E6_Q48 = 26'd44798134;
	localparam logic [18:0] DT_MAX_US         = 19'd500000;
	localparam logic [18:0] DT_DEFAULT_US     = 19'd1000;
	localparam logic [15:0] CLAMP_Q16         = 16'd37814;

	// Divisors of the sine polynomial terms.
	localparam logic [15:0] DIV_TERM_A = 16'd42;
	localparam logic [15:0] DIV_TERM_B = 16'd20;
	localparam logic [15:0] DIV_TERM_C = 16'd6;

	// Register reset values.
	localparam logic [15:0] SUPPLY_RESET = 16'd3072;
	localparam logic [5:0]  POLE_RESET   = 6'd7;

	// Serial arithmetic unit sizes.
	localparam int MUL_A_W = 51;
	localparam int MUL_B_W = 32;
	localparam int DIV_N_W = 40;
	localparam int DIV_D_W = 16;
	localparam logic [5:0] MUL_STEPS = 6'd32;
	localparam logic [5:0] DIV_STEPS = 6'd40;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_MODE    = 3'd0,
		CFG_VLIMIT  = 3'd1,
		CFG_SUPPLY  = 3'd2,
		CFG_POLES   = 3'd3,
		CFG_ZOFFSET = 3'd4
	} cfg_index_t;

	// Sequencer states, one-hot.
	typedef enum logic [16:0] {
		ST_IDLE   = 17'h00001,
		ST_PREP   = 17'h00002,
		ST_MUL_TD = 17'h00004,
		ST_MUL_K  = 17'h00008,
		ST_DIV_U  = 17'h00010,
		ST_ELEC   = 17'h00020,
		ST_SIN_X  = 17'h00040,
		ST_SIN_X2 = 17'h00080,
		ST_DIV42  = 17'h00100,
		ST_MUL_A  = 17'h00200,
		ST_DIV20  = 17'h00400,
		ST_MUL_B  = 17'h00800,
		ST_DIV6   = 17'h01000,
		ST_MUL_C  = 17'h02000,
		ST_MUL_S  = 17'h04000,
		ST_MUL_T  = 17'h08000,
		ST_DUTY   = 17'h10000
	} state_t;

endpackage

[hw/rtl/open_loop_foc_svpwm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_loop_foc_svpwm: open-loop field-oriented drive with space-vector PWM
// Integrates speed into shaft angle (or takes the sensor angle), then computes
// three sector-based SVPWM duties from the normalized q voltage.
// ----------------------------------------------------------------------------
// One input beat yields one output beat of three duties. The work is done by one
// shared shift-add multiplier (one bit per cycle) and one shared restoring
// divider (one quotient bit per cycle); the two sine evaluations of each tick
// use ten of these operations apiece. A new input beat is taken while a
// finished result still waits at the output register.
module open_loop_foc_svpwm #(
	parameter int ANGLE_BITS = olfs_pkg::ANGLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: target [31:0], timestamp_us [63:32], sensor_angle [79:64]
	input  logic [79:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: duty_a [15:0], duty_b [31:16], duty_c [47:32]
	output logic [47:0] m_axis_tdata
);
	import olfs_pkg::*;

	localparam int AW = ANGLE_BITS;
	localparam logic [AW:0]   ONE_A   = {1'b1, {AW{1'b0}}};
	localparam logic [AW-1:0] QUARTER = {2'b01, {(AW-2){1'b0}}};

	// Control state.
	state_t        state_q;
	logic [5:0]    cnt_q;
	logic          out_valid_q;
	logic          mode_q;
	logic [15:0]   vlim_q;
	logic [15:0]   supply_q;
	logic [5:0]    ppc_q;
	logic [15:0]   zoff_q;
	logic [AW-1:0] shaft_q;
	logic [31:0]   last_ts_q;

	// Datapath registers.
	logic [31:0]        tv_q;
	logic [31:0]        now_q;
	logic [15:0]        sens_q;
	logic [MUL_A_W-1:0] mul_a_q;
	logic [MUL_A_W-1:0] mul_h_q;
	logic [MUL_B_W-1:0] mul_l_q;
	logic [DIV_D_W-1:0] div_d_q;
	logic [DIV_D_W-1:0] div_r_q;
	logic [DIV_N_W-1:0] div_n_q;
	logic [15:0]        uabs_q;
	logic               u_neg_q;
	logic [2:0]         sector_q;
	logic [AW-1:0]      r_q;
	logic               sel_q;
	logic [28:0]        x_q;
	logic [28:0]        x2_q;
	logic [17:0]        t1m_q;
	logic [17:0]        t2m_q;
	logic [15:0]        duty_a_q;
	logic [15:0]        duty_b_q;
	logic [15:0]        duty_c_q;

	// Serial multiplier step: add the multiplicand on a set bit, shift right.
	logic [MUL_A_W:0]           mul_sum;
	logic [MUL_A_W+MUL_B_W-1:0] prod;
	assign mul_sum = {1'b0, mul_h_q} + (mul_l_q[0] ? {1'b0, mul_a_q} : '0);
	assign prod    = {mul_h_q, mul_l_q};

	// Restoring divider step: one quotient bit per cycle.
	logic [DIV_D_W:0]   div_sh;
	logic               div_ge;
	logic [DIV_D_W:0]   div_diff;
	assign div_sh   = {div_r_q, div_n_q[DIV_N_W-1]};
	assign div_ge   = div_sh >= {1'b0, div_d_q};
	assign div_diff = div_sh - {1'b0, div_d_q};

	// Elapsed time with the out-of-range fallback.
	logic [31:0] ts_diff;
	logic [18:0] dt;
	assign ts_diff = now_q - last_ts_q;
	assign dt = (ts_diff == 32'd0 || ts_diff > 32'(DT_MAX_US)) ? DT_DEFAULT_US
		: ts_diff[18:0];

	logic [15:0] sup;
	logic [31:0] tv_abs;
	assign sup    = (supply_q == 16'd0) ? 16'd1 : supply_q;
	assign tv_abs = tv_q[31] ? (~tv_q + 32'd1) : tv_q;

	// Widening of 16-bit turn fractions to the angle resolution.
	logic [AW+15:0] sens_wide;
	logic [AW+15:0] zoff_wide;
	assign sens_wide = {sens_q, {AW{1'b0}}};
	assign zoff_wide = {zoff_q, {AW{1'b0}}};

	// Electrical angle, sector and position within the sector.
	logic [AW+5:0] pmul;
	logic [AW-1:0] elec;
	logic [AW+2:0] six;
	assign pmul = {6'd0, shaft_q} * {{AW{1'b0}}, ppc_q};
	assign elec = pmul[AW-1:0] - zoff_wide[AW+15:16] + QUARTER;
	assign six  = ({3'b000, elec} << 2) + ({3'b000, elec} << 1);

	// Results pulled from the arithmetic units.
	logic [15:0] u_clamped;
	logic [28:0] coef;
	logic [28:0] q28;
	assign u_clamped = (div_n_q > DIV_N_W'(CLAMP_Q16)) ? CLAMP_Q16 : div_n_q[15:0];
	assign coef      = ONE_Q28 - div_n_q[28:0];
	assign q28       = prod[56:28];

	// Duty computation in signed arithmetic.
	logic signed [21:0] t1s, t2s, t0s, pa, pb, pc;
	assign t1s = u_neg_q ? -$signed({4'd0, t1m_q}) : $signed({4'd0, t1m_q});
	assign t2s = u_neg_q ? -$signed({4'd0, t2m_q}) : $signed({4'd0, t2m_q});
	assign t0s = 22'sd65536 - t1s - t2s;

	always_comb begin
		case (sector_q)
			3'd0: begin pa = t1s + t2s; pb = t2s;       pc = '0;        end
			3'd1: begin pa = t1s;       pb = t1s + t2s; pc = '0;        end
			3'd2: begin pa = '0;        pb = t1s + t2s; pc = t2s;       end
			3'd3: begin pa = '0;        pb = t1s;       pc = t1s + t2s; end
			3'd4: begin pa = t2s;       pb = '0;        pc = t1s + t2s; end
			default: begin pa = t1s + t2s; pb = '0;     pc = t1s;       end
		endcase
	end

	function automatic logic [15:0] duty_sat(input logic signed [21:0] part,
			input logic signed [21:0] t0);
		logic signed [21:0] twice;
		twice = (part <<< 1) + t0;
		if (twice < 0) return 16'd0;
		else if (twice > 22'sd131071) return 16'hFFFF;
		else return twice[16:1];
	endfunction

	logic op_done;
	assign op_done = (cnt_q == 6'd0);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {duty_c_q, duty_b_q, duty_a_q};

	// Sequencer, configuration and persistent state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			mode_q      <= 1'b0;
			vlim_q      <= '0;
			supply_q    <= SUPPLY_RESET;
			ppc_q       <= POLE_RESET;
			zoff_q      <= '0;
			shaft_q     <= '0;
			last_ts_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MODE:    mode_q   <= cfg_wdata[0];
					CFG_VLIMIT:  vlim_q   <= cfg_wdata;
					CFG_SUPPLY:  supply_q <= cfg_wdata;
					CFG_POLES:   ppc_q    <= cfg_wdata[5:0];
					CFG_ZOFFSET: zoff_q   <= cfg_wdata;
					default: ;
				endcase
			end
			// The duty step sets the valid flag itself, so it is cleared elsewhere only.
			if (out_valid_q && m_axis_tready && state_q != ST_DUTY) out_valid_q <= 1'b0;
			if (!op_done) cnt_q <= cnt_q - 6'd1;

			unique case (state_q)
				ST_IDLE: if (s_axis_tvalid) state_q <= ST_PREP;
				ST_PREP: begin
					if (mode_q) begin
						shaft_q <= sens_wide[AW+15:16];
						cnt_q   <= DIV_STEPS;
						state_q <= ST_DIV_U;
					end else begin
						last_ts_q <= now_q;
						cnt_q     <= MUL_STEPS;
						state_q   <= ST_MUL_TD;
					end
				end
				ST_MUL_TD: if (op_done) begin
					cnt_q   <= MUL_STEPS;
					state_q <= ST_MUL_K;
				end
				ST_MUL_K: if (op_done) begin
					if (tv_q[31]) shaft_q <= shaft_q - prod[63:64-AW];
					else shaft_q <= shaft_q + prod[63:64-AW];
					cnt_q   <= DIV_STEPS;
					state_q <= ST_DIV_U;
				end
				ST_DIV_U: if (op_done) state_q <= ST_ELEC;
				ST_ELEC: begin
					cnt_q   <= MUL_STEPS;
					state_q <= ST_SIN_X;
				end
				ST_SIN_X:  if (op_done) begin cnt_q <= MUL_STEPS; state_q <= ST_SIN_X2; end
				ST_SIN_X2: if (op_done) begin cnt_q <= DIV_STEPS; state_q <= ST_DIV42; end
				ST_DIV42:  if (op_done) begin cnt_q <= MUL_STEPS; state_q <= ST_MUL_A; end
				ST_MUL_A:  if (op_done) begin cnt_q <= DIV_STEPS; state_q <= ST_DIV20; end
				ST_DIV20:  if (op_done) begin cnt_q <= MUL_STEPS; state_q <= ST_MUL_B; end
				ST_MUL_B:  if (op_done) begin cnt_q <= DIV_STEPS; state_q <= ST_DIV6; end
				ST_DIV6:   if (op_done) begin cnt_q <= MUL_STEPS; state_q <= ST_MUL_C; end
				ST_MUL_C:  if (op_done) begin cnt_q <= MUL_STEPS; state_q <= ST_MUL_S; end
				ST_MUL_S:  if (op_done) begin cnt_q <= MUL_STEPS; state_q <= ST_MUL_T; end
				ST_MUL_T: if (op_done) begin
					if (!sel_q) begin
						cnt_q   <= MUL_STEPS;
						state_q <= ST_SIN_X;
					end else begin
						state_q <= ST_DUTY;
					end
				end
				ST_DUTY: if (!out_valid_q || m_axis_tready) begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: unit stepping and operand loads per sequencer step.
	always_ff @(posedge clk) begin
		if (!op_done) begin
			mul_h_q <= mul_sum[MUL_A_W:1];
			mul_l_q <= {mul_sum[0], mul_l_q[MUL_B_W-1:1]};
			div_r_q <= div_ge ? div_diff[DIV_D_W-1:0] : div_sh[DIV_D_W-1:0];
			div_n_q <= {div_n_q[DIV_N_W-2:0], div_ge};
		end

		unique case (state_q)
			ST_IDLE: if (s_axis_tvalid) begin
				tv_q   <= s_axis_tdata[31:0];
				now_q  <= s_axis_tdata[63:32];
				sens_q <= s_axis_tdata[79:64];
			end
			ST_PREP: begin
				mul_a_q <= MUL_A_W'(tv_abs);
				mul_h_q <= '0;
				mul_l_q <= MUL_B_W'(dt);
				div_d_q <= sup;
				div_r_q <= '0;
				div_n_q <= {tv_abs, 8'd0};
			end
			ST_MUL_TD: if (op_done) begin
				mul_a_q <= prod[MUL_A_W-1:0];
				mul_h_q <= '0;
				mul_l_q <= MUL_B_W'(INV_TWO_PI_E6_Q48);
			end
			ST_MUL_K: if (op_done) begin
				div_d_q <= sup;
				div_r_q <= '0;
				div_n_q <= {8'd0, vlim_q, 16'd0};
			end
			ST_DIV_U: if (op_done) begin
				uabs_q  <= u_clamped;
				u_neg_q <= mode_q & tv_q[31];
				sel_q   <= 1'b0;
			end
			ST_ELEC: begin
				sector_q <= six[AW+2:AW];
				r_q      <= six[AW-1:0];
				mul_a_q  <= MUL_A_W'(ONE_A - {1'b0, six[AW-1:0]});
				mul_h_q  <= '0;
				mul_l_q  <= MUL_B_W'(PI3_Q28);
			end
			ST_SIN_X: if (op_done) begin
				x_q     <= prod[AW+28:AW];
				mul_a_q <= MUL_A_W'(prod[AW+28:AW]);
				mul_h_q <= '0;
				mul_l_q <= MUL_B_W'(prod[AW+28:AW]);
			end
			ST_SIN_X2: if (op_done) begin
				x2_q    <= q28;
				div_d_q <= DIV_TERM_A;
				div_r_q <= '0;
				div_n_q <= DIV_N_W'(q28);
			end
			ST_DIV42, ST_DIV20: if (op_done) begin
				mul_a_q <= MUL_A_W'(x2_q);
				mul_h_q <= '0;
				mul_l_q <= MUL_B_W'(coef);
			end
			ST_MUL_A: if (op_done) begin
				div_d_q <= DIV_TERM_B;
				div_r_q <= '0;
				div_n_q <= DIV_N_W'(q28);
			end
			ST_MUL_B: if (op_done) begin
				div_d_q <= DIV_TERM_C;
				div_r_q <= '0;
				div_n_q <= DIV_N_W'(q28);
			end
			ST_DIV6: if (op_done) begin
				mul_a_q <= MUL_A_W'(x_q);
				mul_h_q <= '0;
				mul_l_q <= MUL_B_W'(coef);
			end
			ST_MUL_C: if (op_done) begin
				mul_a_q <= MUL_A_W'(q28);
				mul_h_q <= '0;
				mul_l_q <= MUL_B_W'(SQRT3_Q28);
			end
			ST_MUL_S: if (op_done) begin
				mul_a_q <= MUL_A_W'(prod[57:28]);
				mul_h_q <= '0;
				mul_l_q <= MUL_B_W'(uabs_q);
			end
			ST_MUL_T: if (op_done) begin
				if (!sel_q) begin
					t1m_q   <= prod[45:28];
					sel_q   <= 1'b1;
					mul_a_q <= MUL_A_W'(r_q);
					mul_h_q <= '0;
					mul_l_q <= MUL_B_W'(PI3_Q28);
				end else begin
					t2m_q <= prod[45:28];
				end
			end
			ST_DUTY: if (!out_valid_q || m_axis_tready) begin
				duty_a_q <= duty_sat(pa, t0s);
				duty_b_q <= duty_sat(pb, t0s);
				duty_c_q <= duty_sat(pc, t0s);
			end
			default: ;
		endcase
	end

	// The elapsed time handed to the multiplier is never zero or out of range.
	a_dt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_TD && cnt_q == MUL_STEPS)
		|-> (mul_l_q != '0 && mul_l_q <= MUL_B_W'(DT_MAX_US)))
		else $error("elapsed time out of range");

	// The normalized voltage magnitude is clamped before the sine stages.
	a_u_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ELEC) |-> (uabs_q <= CLAMP_Q16))
		else $error("normalized voltage not clamped");

	// A pending result blocks the next duty write.
	a_duty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUTY && out_valid_q && !m_axis_tready) |=> (state_q == ST_DUTY))
		else $error("pending result overwritten");

endmodule
